// ===== hw/rtl/a5_frame_parser_sum16_check_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sum16 frame parser
// These macros expect the including module to have signals named clk and rst.
// ----------------------------------------------------------------------------
`ifndef A5_FRAME_PARSER_SUM16_CHECK_DEFINES_SVH
`define A5_FRAME_PARSER_SUM16_CHECK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define A5FP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define A5FP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/a5fp_pkg.sv =====
// ----------------------------------------------------------------------------
// a5fp_pkg
// Types and constants shared by the sum16 frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package a5fp_pkg;

  localparam logic [7:0] START_BYTE = 8'hFF;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PUMP_ADDRESS       = 3'd0;
  localparam logic [2:0] CFG_CONTROLLER_ADDRESS = 3'd1;
  localparam logic [2:0] CFG_PREFIX_VALUE       = 3'd2;
  localparam logic [2:0] CFG_REVISION_VALUE     = 3'd3;
  localparam logic [2:0] CFG_STATUS_ACTION_CODE = 3'd4;

  localparam logic [7:0] RST_PUMP_ADDRESS       = 8'd96;
  localparam logic [7:0] RST_CONTROLLER_ADDRESS = 8'd16;
  localparam logic [7:0] RST_PREFIX_VALUE       = 8'd165;
  localparam logic [7:0] RST_REVISION_VALUE     = 8'd0;
  localparam logic [7:0] RST_STATUS_ACTION_CODE = 8'd7;

  // Data byte positions that carry the pump readings.
  localparam logic [7:0] STATUS_FIRST = 8'd3;
  localparam logic [7:0] STATUS_LAST  = 8'd8;
  localparam int         STATUS_DEPTH = 6;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'd0,
    PH_PREFIX = 4'd1,
    PH_REV    = 4'd2,
    PH_DST    = 4'd3,
    PH_SRC    = 4'd4,
    PH_CMD    = 4'd5,
    PH_LEN    = 4'd6,
    PH_DATA   = 4'd7,
    PH_CHKH   = 4'd8,
    PH_CHKL   = 4'd9
  } phase_t;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_dest;
    logic [7:0]  frame_source;
    logic [7:0]  frame_action;
    logic [7:0]  frame_length;
    logic        checksum_ok;
    logic        status_valid;
    logic [15:0] pump_watts;
    logic [15:0] pump_rpm;
    logic [7:0]  pump_flow;
    logic [7:0]  pump_power;
  } result_t;

endpackage

// ===== hw/rtl/a5_frame_parser_sum16_check.sv =====
// ----------------------------------------------------------------------------
// a5_frame_parser_sum16_check
// Byte-serial frame parser with a 16-bit wrapping sum check and pump status
// decode.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   input   | in        | in_valid / in_stall | rx_byte
//   output  | out       | out_valid/out_stall | out_kind .. pump_power
//   config  | in        | cfg_write           | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low; each data byte or frame-end
// result is registered in the output register, or parked in the skid register.
// The output register is backed by a one-entry skid register; in_stall is the
// skid register's full flag, so input stalls only after two results are held.
// Reset is synchronous; it clears the parse phase and the handshake flags and
// loads the configuration registers with their reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "a5_frame_parser_sum16_check_defines.svh"

module a5_frame_parser_sum16_check
  import a5fp_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Input requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // Output requests
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  frame_dest,
  output logic [7:0]  frame_source,
  output logic [7:0]  frame_action,
  output logic [7:0]  frame_length,
  output logic        checksum_ok,
  output logic        status_valid,
  output logic [15:0] pump_watts,
  output logic [15:0] pump_rpm,
  output logic [7:0]  pump_flow,
  output logic [7:0]  pump_power
);

  localparam logic [7:0] MaxPayload = 8'(MAX_PAYLOAD);

  // Configuration registers
  logic [7:0] pump_address;
  logic [7:0] controller_address;
  logic [7:0] prefix_value;
  logic [7:0] revision_value;
  logic [7:0] status_action_code;

  // Parser state
  phase_t      phase, phase_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  hdr_dest, hdr_dest_next;
  logic [7:0]  hdr_source, hdr_source_next;
  logic [7:0]  hdr_action, hdr_action_next;
  logic [7:0]  hdr_length, hdr_length_next;
  logic [7:0]  bytes_taken, bytes_taken_next;
  logic [7:0]  rx_check_high, rx_check_high_next;
  logic [7:0]  status_bytes [STATUS_DEPTH];

  // Output register and skid register
  logic    skid_valid;
  result_t out_res;
  result_t skid_res;

  logic    accept;
  logic    out_take;
  logic    res_fire;
  result_t res_new;
  logic    known_addr;
  logic    data_overrun;
  logic    clear_status;
  logic    status_write;
  logic [2:0]  status_idx;
  logic [15:0] sum_plus;
  logic [7:0]  taken_plus;
  logic [15:0] rx_check;
  logic        sum_match;
  logic        is_status;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  assign known_addr   = (rx_byte == pump_address) || (rx_byte == controller_address);
  assign data_overrun = (bytes_taken > hdr_length) || (bytes_taken >= MaxPayload);
  assign sum_plus     = running_sum + {8'd0, rx_byte};
  assign taken_plus   = bytes_taken + 8'd1;
  assign rx_check     = {rx_check_high, rx_byte};
  assign sum_match    = (rx_check == running_sum);
  assign is_status    = sum_match && (hdr_action == status_action_code);
  assign status_idx   = 3'(bytes_taken - STATUS_FIRST);

  // Next phase
  always_comb begin
    phase_next = PH_HUNT;
    case (phase)
      PH_PREFIX: phase_next = (rx_byte == prefix_value) ? PH_REV : PH_HUNT;
      PH_REV:    phase_next = (rx_byte == revision_value) ? PH_DST : PH_HUNT;
      PH_DST:    phase_next = known_addr ? PH_SRC : PH_HUNT;
      PH_SRC:    phase_next = known_addr ? PH_CMD : PH_HUNT;
      PH_CMD:    phase_next = PH_LEN;
      PH_LEN:    phase_next = (rx_byte == 8'd0) ? PH_CHKH : PH_DATA;
      PH_DATA: begin
        if (data_overrun) begin
          phase_next = PH_HUNT;
        end else if (taken_plus == hdr_length) begin
          phase_next = PH_CHKH;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_CHKH:   phase_next = PH_CHKL;
      PH_CHKL:   phase_next = PH_HUNT;
      default:   phase_next = (rx_byte == START_BYTE) ? PH_PREFIX : PH_HUNT;
    endcase
  end

  // Datapath updates and result for the byte on the input
  always_comb begin
    running_sum_next   = running_sum;
    hdr_dest_next      = hdr_dest;
    hdr_source_next    = hdr_source;
    hdr_action_next    = hdr_action;
    hdr_length_next    = hdr_length;
    bytes_taken_next   = bytes_taken;
    rx_check_high_next = rx_check_high;
    clear_status       = 1'b0;
    status_write       = 1'b0;
    res_fire           = 1'b0;
    res_new            = '0;
    case (phase)
      PH_PREFIX: begin
        if (rx_byte == prefix_value) begin
          clear_status       = 1'b1;
          hdr_dest_next      = 8'd0;
          hdr_source_next    = 8'd0;
          hdr_action_next    = 8'd0;
          hdr_length_next    = 8'd0;
          bytes_taken_next   = 8'd0;
          rx_check_high_next = 8'd0;
          running_sum_next   = {8'd0, rx_byte};
        end
      end
      PH_REV: begin
        if (rx_byte == revision_value) begin
          running_sum_next = sum_plus;
        end
      end
      PH_DST: begin
        if (known_addr) begin
          hdr_dest_next    = rx_byte;
          running_sum_next = sum_plus;
        end
      end
      PH_SRC: begin
        if (known_addr) begin
          hdr_source_next  = rx_byte;
          running_sum_next = sum_plus;
        end
      end
      PH_CMD: begin
        hdr_action_next  = rx_byte;
        running_sum_next = sum_plus;
      end
      PH_LEN: begin
        hdr_length_next  = rx_byte;
        bytes_taken_next = 8'd0;
        running_sum_next = sum_plus;
      end
      PH_DATA: begin
        if (!data_overrun) begin
          status_write         = (bytes_taken >= STATUS_FIRST) && (bytes_taken <= STATUS_LAST);
          running_sum_next     = sum_plus;
          bytes_taken_next     = taken_plus;
          res_fire             = 1'b1;
          res_new.out_kind     = KIND_DATA;
          res_new.payload_byte = rx_byte;
        end
      end
      PH_CHKH: begin
        rx_check_high_next = rx_byte;
      end
      PH_CHKL: begin
        res_fire             = 1'b1;
        res_new.out_kind     = KIND_FRAME;
        res_new.frame_dest   = hdr_dest;
        res_new.frame_source = hdr_source;
        res_new.frame_action = hdr_action;
        res_new.frame_length = hdr_length;
        res_new.checksum_ok  = sum_match;
        res_new.status_valid = is_status;
        if (is_status) begin
          res_new.pump_watts = {status_bytes[0], status_bytes[1]};
          res_new.pump_rpm   = {status_bytes[2], status_bytes[3]};
          res_new.pump_flow  = status_bytes[4];
          res_new.pump_power = status_bytes[5];
        end
      end
      default: begin
      end
    endcase
  end

  // Configuration registers and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pump_address       <= RST_PUMP_ADDRESS;
      controller_address <= RST_CONTROLLER_ADDRESS;
      prefix_value       <= RST_PREFIX_VALUE;
      revision_value     <= RST_REVISION_VALUE;
      status_action_code <= RST_STATUS_ACTION_CODE;
      phase              <= PH_HUNT;
      out_valid          <= 1'b0;
      skid_valid         <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_PUMP_ADDRESS:       pump_address       <= cfg_data;
          CFG_CONTROLLER_ADDRESS: controller_address <= cfg_data;
          CFG_PREFIX_VALUE:       prefix_value       <= cfg_data;
          CFG_REVISION_VALUE:     revision_value     <= cfg_data;
          CFG_STATUS_ACTION_CODE: status_action_code <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        phase <= phase_next;
      end
      // A new result goes to the output register when it is free or being
      // drained this cycle, otherwise it parks in the skid register.
      if (accept && res_fire) begin
        if (!out_valid || out_take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      running_sum   <= running_sum_next;
      hdr_dest      <= hdr_dest_next;
      hdr_source    <= hdr_source_next;
      hdr_action    <= hdr_action_next;
      hdr_length    <= hdr_length_next;
      bytes_taken   <= bytes_taken_next;
      rx_check_high <= rx_check_high_next;
      if (clear_status) begin
        for (int i = 0; i < STATUS_DEPTH; i++) begin
          status_bytes[i] <= 8'd0;
        end
      end else if (status_write) begin
        status_bytes[status_idx] <= rx_byte;
      end
    end
    if (accept && res_fire) begin
      if (!out_valid || out_take) begin
        out_res <= res_new;
      end else begin
        skid_res <= res_new;
      end
    end else if (out_take && skid_valid) begin
      out_res <= skid_res;
    end
  end

  assign out_kind     = out_res.out_kind;
  assign payload_byte = out_res.payload_byte;
  assign frame_dest   = out_res.frame_dest;
  assign frame_source = out_res.frame_source;
  assign frame_action = out_res.frame_action;
  assign frame_length = out_res.frame_length;
  assign checksum_ok  = out_res.checksum_ok;
  assign status_valid = out_res.status_valid;
  assign pump_watts   = out_res.pump_watts;
  assign pump_rpm     = out_res.pump_rpm;
  assign pump_flow    = out_res.pump_flow;
  assign pump_power   = out_res.pump_power;

  // The skid register only fills behind a held output register.
  `A5FP_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid,
    "skid register holds a result while the output register is empty")

  // A status verdict is only given for a frame whose sum matched.
  `A5FP_ASSERT_SAME(a_status_needs_sum, out_valid && out_res.status_valid,
    (out_res.out_kind == KIND_FRAME) && out_res.checksum_ok,
    "status reported without a matching checksum")

  // While in the data phase, fewer bytes than declared have been taken.
  `A5FP_ASSERT_SAME(a_data_count, phase == PH_DATA,
    (bytes_taken < hdr_length) && (bytes_taken <= MaxPayload),
    "data byte count out of range in data phase")

  // A parked result is handed to the output register when the output drains.
  `A5FP_ASSERT_NEXT(a_skid_drains, skid_valid && out_take, out_valid && !skid_valid,
    "skid register did not drain into the output register")

endmodule
